@@ design/fir8_pkg.sv @@
// Shared constants for the eight-tap FIR filter.
package fir8_pkg;

  localparam int TAPS_DEF        = 8;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_W          = 16;
  localparam int NUM_COEFS       = 8;
  localparam int COEF_IDX_W      = 3;
  localparam int CFG_IDX_W       = 4;
  localparam int ROUND_SHIFT     = 15;
  localparam int ROUND_BIAS      = 1 << (ROUND_SHIFT - 1);
  // Eight products of SAMPLE_BITS x COEF_W bits need three guard bits.
  localparam int ACC_GUARD       = 3;

endpackage

@@ design/fir8_if.sv @@
// Valid/ready stream interfaces for samples in and filter results out.
interface fir8_in_if #(
  parameter int SAMPLE_BITS = fir8_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fir8_out_if #(
  parameter int SAMPLE_BITS = fir8_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

@@ design/fir8_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fir8_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/fir_filter_8tap.sv @@
// Direct-form FIR filter: delay line in RAM, one multiply-accumulate per tap per cycle.
// Each sample is read tap by tap through the single RAM read port into one shared
//   multiplier, accumulated, rounded and registered at the output; a new sample is
//   accepted only once that result is loaded, which waits while the output stalls.
// Reset (synchronous, active high): coefficients zero, delay line reads as zero
//   through per-entry valid bits, ring pointer zero, no result pending.
module fir_filter_8tap #(
  parameter int TAPS        = fir8_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fir8_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fir8_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fir8_pkg::COEF_W-1:0]    cfg_data,
  fir8_in_if.sink                        in_ch,
  fir8_out_if.source                     out_ch
);

  import fir8_pkg::*;

  localparam int PTR_W  = $clog2(TAPS);
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int ACC_W  = PROD_W + ACC_GUARD;
  localparam int SH_W   = ACC_W - ROUND_SHIFT;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-(1 << (SAMPLE_BITS - 1)));

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [COEF_W-1:0]      coef [NUM_COEFS];
  logic [TAPS-1:0]               entry_vld;
  logic [PTR_W-1:0]              ptr;
  logic [PTR_W-1:0]              rd_addr;
  logic [PTR_W-1:0]              tap;
  logic [PTR_W-1:0]              tap_rd;
  logic                          rd_vld;
  logic                          rd_entry_vld;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] rd_sample;
  logic signed [PROD_W-1:0]      prod;
  logic                          prod_vld;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       biased;
  logic signed [SH_W-1:0]        rounded;
  logic signed [SH_W-1:0]        clamped;
  logic                          in_acc;
  logic                          issue;
  logic                          load_out;
  logic                          out_valid;
  logic [SAMPLE_BITS-1:0]        filtered;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(TAPS - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign issue       = (state == ST_RUN);
  assign load_out    = (state == ST_DRAIN) && !rd_vld && !prod_vld &&
                       (!out_valid || out_ch.ready);

  fir8_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (ptr),
    .wdata (in_ch.sample_in),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (tap == PTR_W'(TAPS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      entry_vld <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        entry_vld[ptr] <= 1'b1;
        ptr            <= wrap_inc(ptr);
      end
    end
  end

  // Coefficient registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) coef[i] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEFS))) begin
      coef[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
    end
  end

  // Read sequencer: oldest entry first, newest last.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_addr <= wrap_inc(ptr);
      tap     <= '0;
    end else if (issue) begin
      rd_addr <= wrap_inc(rd_addr);
      tap     <= tap + PTR_W'(1);
    end
    tap_rd       <= tap;
    rd_entry_vld <= entry_vld[rd_addr];
  end

  assign rd_sample = rd_entry_vld ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= issue;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(rd_sample * coef[COEF_IDX_W'(tap_rd)]);
    if (in_acc) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up, then clamp to the sample range.
  always_comb begin
    biased  = acc + ACC_W'(ROUND_BIAS);
    rounded = SH_W'(biased >>> ROUND_SHIFT);
    priority if (rounded > SAT_HI) begin
      clamped = SAT_HI;
    end else if (rounded < SAT_LO) begin
      clamped = SAT_LO;
    end else begin
      clamped = rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered <= SAMPLE_BITS'(clamped);
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.filtered = filtered;

endmodule

@@ design/fir8_checker.sv @@
// Port-level assertions for the FIR filter, bound to the top level.
module fir8_checker #(
  parameter int TAPS        = fir8_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fir8_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] filtered
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Accepting a sample drops ready to hold off new requests.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("request accepted while busy");

  // With the output slot free, the result lands after a fixed latency.
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc && (!out_valid || out_ready) |-> ##(TAPS + 4) (out_valid && in_ready))
    else $error("result not delivered at expected cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("stalled result changed");

endmodule

bind fir_filter_8tap fir8_checker #(
  .TAPS        (TAPS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fir8_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .filtered  (out_ch.filtered)
);

@@ dv/tb.sv @@
// Self-checking bench for the eight-tap FIR: impulse, saturation, rounding, random, stalls.
module tb;
  import fir8_pkg::*;

  localparam int TAPS        = TAPS_DEF;
  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = TAPS + 8;
  localparam int LIMIT       = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 110;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_0   = '0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(NUM_COEFS);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  localparam logic signed [SB-1:0] Q15_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] Q15_MIN = {1'b1, {(SB-1){1'b0}}};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  fir8_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  fir8_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  fir_filter_8tap #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SB)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Filter state as the testbench sees it
  logic signed [COEF_W-1:0] coef_q [NUM_COEFS];
  logic signed [SB-1:0]     ring [TAPS];
  logic [COEF_IDX_W-1:0]    oldest;
  logic signed [SB-1:0]     pending_outputs [$];
  logic signed [SB-1:0]     want;

  bit gaps_on;
  int hold_request;
  int samples_sent;
  int results_seen;
  int settings_used;
  int mismatches;
  int errors;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Store the sample over the oldest entry, sum coef_k times the k-th oldest, round and clamp.
  function automatic logic signed [SB-1:0] filter_step(input logic signed [SB-1:0] s);
    longint acc;
    longint r;
    logic [COEF_IDX_W-1:0] idx;
    ring[oldest] = s;
    oldest = COEF_IDX_W'((oldest + 1) % TAPS);
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      idx = COEF_IDX_W'((oldest + k) % TAPS);
      acc += longint'(coef_q[k]) * longint'(ring[idx]);
    end
    r = (acc + ROUND_BIAS) >>> ROUND_SHIFT;
    if (r > longint'(Q15_MAX)) r = longint'(Q15_MAX);
    if (r < longint'(Q15_MIN)) r = longint'(Q15_MIN);
    return SB'(r);
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return Q15_MAX;
      1:       return Q15_MIN;
      2:       return SB'(int'($urandom_range(0, 32)) - 16);
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx < NUM_COEFS) coef_q[idx[COEF_IDX_W-1:0]] = data;
  endtask

  task automatic send_sample(input logic signed [SB-1:0] s);
    int gap;
    gap = gaps_on ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.sample_in = s;
    do @(posedge clk); while (!in_ch.ready);
    pending_outputs.push_back(filter_step(s));
    samples_sent++;
  endtask

  // Drop the request, then wait for every result and the pipeline to settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // coef_7 stays at reset, so the first output is zero and the rest trace coef_6 down to coef_0.
  task automatic test_impulse();
    for (int k = 0; k < NUM_COEFS - 1; k++)
      write_reg(REG_COEF_0 + CFG_IDX_W'(k), COEF_W'($urandom));
    settings_used++;
    send_sample(Q15_MAX);
    repeat (TAPS - 1) send_sample('0);
    drain();
  endtask

  task automatic test_extremes();
    for (int k = 0; k < NUM_COEFS; k++)
      write_reg(REG_COEF_0 + CFG_IDX_W'(k), Q15_MAX);
    settings_used++;
    repeat (3) send_sample(Q15_MAX);
    drain();
    for (int k = 0; k < NUM_COEFS; k++)
      write_reg(REG_COEF_0 + CFG_IDX_W'(k), Q15_MIN);
    settings_used++;
    repeat (2) send_sample(Q15_MAX);
    repeat (3) send_sample(Q15_MIN);
    drain();
    // One LSB on the newest tap exposes round half up.
    for (int k = 0; k < NUM_COEFS - 1; k++)
      write_reg(REG_COEF_0 + CFG_IDX_W'(k), '0);
    write_reg(REG_COEF_0 + CFG_IDX_W'(NUM_COEFS - 1), COEF_W'(1));
    settings_used++;
    send_sample(SB'(16'h4000));
    send_sample(SB'(16'hC000));
    send_sample(SB'(16'hBFFF));
    send_sample(SB'(16'h3FFF));
    drain();
    // Writes past the last coefficient must leave the filter unchanged.
    write_reg(REG_SPARE_LO, Q15_MAX);
    write_reg(REG_SPARE_HI, Q15_MAX);
    send_sample(SB'(16'h4000));
    drain();
  endtask

  task automatic test_random_phases();
    logic [COEF_W-1:0] c;
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int k = 0; k < NUM_COEFS; k++) begin
        case (phase)
          1:       c = Q15_MAX;
          2:       c = Q15_MIN;
          3:       c = k[0] ? Q15_MIN : Q15_MAX;
          4:       c = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
          5:       c = ($urandom_range(0, 2) == 0) ? '0 : COEF_W'($urandom);
          default: c = COEF_W'($urandom);
        endcase
        write_reg(REG_COEF_0 + CFG_IDX_W'(k), c);
      end
      write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 7)), COEF_W'($urandom));
      settings_used++;
      gaps_on = (phase != 3);
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      drain();
    end
    gaps_on = 1'b1;
  endtask

  // Hold the output side while requests keep coming so the input stalls.
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (40) send_sample(pick_sample());
    drain();
    gaps_on = 1'b1;
  endtask

  // Output side: draw a stall per result, or take a requested long hold.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      stall        = (hold_request > 0) ? hold_request : (gaps_on ? $urandom_range(0, 17) : 0);
      hold_request = 0;
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("unexpected result %0d with nothing pending", $signed(out_ch.filtered));
      end else begin
        want = pending_outputs.pop_front();
        if (out_ch.filtered !== want) begin
          errors++;
          if (mismatches < MAX_REPORTS)
            $display("mismatch on result %0d: expected %0d, got %0d",
                     results_seen, want, $signed(out_ch.filtered));
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               LIMIT, pending_outputs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_COEF_0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    gaps_on         = 1'b1;
    hold_request    = 0;
    oldest          = '0;
    for (int k = 0; k < NUM_COEFS; k++) coef_q[k] = '0;
    for (int k = 0; k < TAPS; k++) ring[k] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_impulse();
    test_extremes();
    test_random_phases();
    test_backpressure();
    drain();

    errors += pending_outputs.size();
    $display("Filtered %0d samples under %0d coefficient sets, %0d results checked,",
             samples_sent, settings_used, results_seen);
    $display("including saturation, rounding, ignored indexes and a long output stall.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ fir_filter_8tap.f @@
design/fir8_pkg.sv
design/fir8_if.sv
design/fir8_ram.sv
design/fir_filter_8tap.sv
design/fir8_checker.sv
dv/tb.sv
